>>> rtl/rmsp_pkg.sv
// Package for the RMS/power block: widths, register indexes, defaults.
// No dependencies.
package rmsp_pkg;
  localparam int SumBitsDef = 42;
  localparam int CountBitsDef = 12;
  localparam int RmsBits = 24;
  localparam int PowerBits = 40;
  localparam int ScaleBits = 32;
  localparam int ScaleFrac = 16;
  localparam int RootBits = 40;
  localparam int NumLanes = 4;
  localparam logic [0:0] RegCurrentScale = 1'b0;
  localparam logic [0:0] RegVoltageScale = 1'b1;
  localparam logic [ScaleBits-1:0] ScaleReset = 32'd65536;
endpackage

>>> rtl/rmsp_if.sv
// Valid/ready channel interface with source and sink modports.
// Depends on nothing; payload type given as a parameter.
interface rmsp_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/rmsp_lane.sv
// One channel lane: pipelined divide by count, pipelined root, scale, saturate.
// Depends on rmsp_pkg.
module rmsp_lane import rmsp_pkg::*; #(
  parameter int SUM_BITS = SumBitsDef,
  parameter int COUNT_BITS = CountBitsDef
) (
  input  logic clk,
  input  logic en,
  input  logic [SUM_BITS-1:0] sum,
  input  logic [COUNT_BITS-1:0] count,
  input  logic [ScaleBits-1:0] scale,
  output logic [RmsBits-1:0] rms
);
  localparam int MeanBits = 64;
  localparam int DivSt = SUM_BITS;
  localparam int RootSt = RootBits;
  localparam int RemBits = RootBits + 2;

  // restoring division: one quotient bit per stage
  logic [SUM_BITS-1:0] dq [DivSt+1];
  logic [COUNT_BITS:0] dr [DivSt+1];
  logic [COUNT_BITS-1:0] dc [DivSt+1];
  assign dq[0] = sum;
  assign dr[0] = '0;
  assign dc[0] = count;
  for (genvar s = 0; s < DivSt; s++) begin : g_div
    logic [COUNT_BITS:0] t;
    logic [COUNT_BITS:0] q;
    logic [COUNT_BITS:0] rn;
    logic [SUM_BITS-1:0] qn;
    always_comb begin
      t = {dr[s][COUNT_BITS-1:0], dq[s][SUM_BITS-1]};
      q = {1'b0, dc[s]};
      if (t >= q) begin
        rn = t - q;
        qn = {dq[s][SUM_BITS-2:0], 1'b1};
      end else begin
        rn = t;
        qn = {dq[s][SUM_BITS-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dq[s+1] <= qn;
        dr[s+1] <= rn;
        dc[s+1] <= dc[s];
      end
    end
  end

  logic [MeanBits-1:0] mean;
  assign mean = MeanBits'(dq[DivSt]);

  // root digit by digit, pairs of mean*2^16
  logic [MeanBits+15:0] rm [RootSt+1];
  logic [RemBits-1:0] rr [RootSt+1];
  logic [RootBits-1:0] ro [RootSt+1];
  assign rm[0] = {mean, 16'd0};
  assign rr[0] = '0;
  assign ro[0] = '0;
  for (genvar p = 0; p < RootSt; p++) begin : g_root
    localparam int Pos = 2 * (RootSt - 1 - p);
    logic [RemBits-1:0] rem;
    logic [RemBits-1:0] trial;
    logic [RemBits-1:0] rn;
    logic [RootBits-1:0] on;
    always_comb begin
      rem = {rr[p][RemBits-3:0], rm[p][Pos+1 -: 2]};
      trial = {ro[p][RootBits-1:0], 2'b01};
      if (rem >= trial) begin
        rn = rem - trial;
        on = {ro[p][RootBits-2:0], 1'b1};
      end else begin
        rn = rem;
        on = {ro[p][RootBits-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rm[p+1] <= rm[p];
        rr[p+1] <= rn;
        ro[p+1] <= on;
      end
    end
  end

  // root*scale in two 20x32 partial products
  logic [51:0] pl;
  logic [51:0] ph;
  logic [RmsBits-1:0] rms_q;
  logic [72:0] prod;
  always_ff @(posedge clk) begin
    if (en) begin
      pl <= ro[RootSt][19:0] * scale;
      ph <= ro[RootSt][39:20] * scale;
    end
  end
  always_comb begin
    prod = {21'd0, pl} + {1'b0, ph, 20'd0};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (|prod[72:RmsBits+ScaleFrac]) rms_q <= '1;
      else rms_q <= prod[RmsBits+ScaleFrac-1:ScaleFrac];
    end
  end
  assign rms = rms_q;
endmodule

>>> rtl/rmsp_merge.sv
// Merging stage: power of pair one (full product, no saturation needed), zero-count masking.
// Depends on rmsp_pkg.
module rmsp_merge import rmsp_pkg::*; (
  input  logic clk,
  input  logic en,
  input  logic zero,
  input  logic [RmsBits-1:0] rms [NumLanes],
  output logic valid_flag,
  output logic [RmsBits-1:0] rms_out [NumLanes],
  output logic [PowerBits-1:0] power
);
  logic [2*RmsBits-1:0] prod;
  logic [RmsBits-1:0] r1 [NumLanes];
  logic z1;
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= zero ? '0 : rms[0] * rms[2];
      z1 <= zero;
      for (int i = 0; i < NumLanes; i++) r1[i] <= zero ? '0 : rms[i];
    end
  end
  always_comb begin
    valid_flag = !z1;
    rms_out = r1;
    power = prod[2*RmsBits-1:8];
  end
endmodule

>>> rtl/rms_power_from_square_sums.sv
// Top level: four lanes, merge, valid pipeline and output register.
// Depends on rmsp_pkg, rmsp_if, rmsp_lane, rmsp_merge.
//
// channel  dir  payload
// in_ch    in   four square sums, sample count
// out_ch   out  data_valid, four RMS values, apparent_power_a
// cfg      in   we, index, wdata (scale registers)
//
// Divide and root pipelines resolve one bit per stage. One beat per cycle
// is sustained unless out_ch stalls. The pipeline advances whenever the
// last stage is empty or taken, so a stall holds all stages. Reset clears
// the valid bits and loads both scales with 1.0.
module rms_power_from_square_sums import rmsp_pkg::*; #(
  parameter int SUM_BITS = SumBitsDef,
  parameter int COUNT_BITS = CountBitsDef
) (
  input  logic clk,
  input  logic rst,
  rmsp_if.sink in_ch,
  rmsp_if.source out_ch,
  input  logic we,
  input  logic index,
  input  logic [ScaleBits-1:0] wdata
);
  localparam int Lat = SUM_BITS + RootBits + 3;

  logic [ScaleBits-1:0] current_scale;
  logic [ScaleBits-1:0] voltage_scale;
  always_ff @(posedge clk) begin
    if (rst) begin
      current_scale <= ScaleReset;
      voltage_scale <= ScaleReset;
    end else if (we) begin
      if (index == RegCurrentScale) current_scale <= wdata;
      if (index == RegVoltageScale) voltage_scale <= wdata;
    end
  end

  logic en;
  logic [Lat-1:0] vld;
  logic [Lat-2:0] zp;
  assign en = !vld[Lat-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], in_ch.valid};
  end
  always_ff @(posedge clk) begin
    if (en) zp <= {zp[Lat-3:0], in_ch.data.sample_count == '0};
  end

  logic [SUM_BITS-1:0] sums [NumLanes];
  logic [RmsBits-1:0] rms [NumLanes];
  logic [COUNT_BITS-1:0] cnt;
  assign sums[0] = in_ch.data.current_sq_sum_a;
  assign sums[1] = in_ch.data.current_sq_sum_b;
  assign sums[2] = in_ch.data.voltage_sq_sum_a;
  assign sums[3] = in_ch.data.voltage_sq_sum_b;
  // zero count would divide by zero; lane output is masked anyway
  assign cnt = (in_ch.data.sample_count == '0) ? COUNT_BITS'(1) : in_ch.data.sample_count;

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    rmsp_lane #(.SUM_BITS(SUM_BITS), .COUNT_BITS(COUNT_BITS)) u_lane (
      .clk(clk), .en(en), .sum(sums[l]), .count(cnt),
      .scale((l == 0 || l == 1) ? current_scale : voltage_scale),
      .rms(rms[l])
    );
  end

  logic [RmsBits-1:0] ro [NumLanes];
  logic flag;
  logic [PowerBits-1:0] pw;
  rmsp_merge u_merge (
    .clk(clk), .en(en), .zero(zp[Lat-2]), .rms(rms),
    .valid_flag(flag), .rms_out(ro), .power(pw)
  );
  assign out_ch.data.data_valid = flag;
  assign out_ch.data.rms_current_a = ro[0];
  assign out_ch.data.rms_current_b = ro[1];
  assign out_ch.data.rms_voltage_a = ro[2];
  assign out_ch.data.rms_voltage_b = ro[3];
  assign out_ch.data.apparent_power_a = pw;
endmodule

>>> tb/sv/rms_power_from_square_sums_test.sv
// Testbench for rms_power_from_square_sums: random and directed batch records,
// scale register sweeps, in-order check of every result beat against a predictor.
// Depends on rmsp_pkg, rmsp_if and the block itself.
`timescale 1ns / 100ps

module rms_power_from_square_sums_test;
  import rmsp_pkg::*;

  localparam int SumW = SumBitsDef;
  localparam int CntW = CountBitsDef;
  localparam int Latency = SumW + 44;

  typedef struct packed {
    logic [SumW-1:0] current_sq_sum_a;
    logic [SumW-1:0] current_sq_sum_b;
    logic [SumW-1:0] voltage_sq_sum_a;
    logic [SumW-1:0] voltage_sq_sum_b;
    logic [CntW-1:0] sample_count;
  } batch_t;

  typedef struct packed {
    logic data_valid;
    logic [RmsBits-1:0] rms_current_a;
    logic [RmsBits-1:0] rms_current_b;
    logic [RmsBits-1:0] rms_voltage_a;
    logic [RmsBits-1:0] rms_voltage_b;
    logic [PowerBits-1:0] apparent_power_a;
  } rms_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic we = 1'b0;
  logic index = 1'b0;
  logic [ScaleBits-1:0] wdata = '0;

  rmsp_if #(.payload_t(batch_t)) in_ch (clk);
  rmsp_if #(.payload_t(rms_t)) out_ch (clk);

  rms_power_from_square_sums u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .we(we), .index(index), .wdata(wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  batch_t pending_batches[$];
  rms_t expected_rms[$];
  logic [ScaleBits-1:0] cur_scale = ScaleReset;
  logic [ScaleBits-1:0] volt_scale = ScaleReset;
  int errors = 0;
  bit calm = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [63:0] root_q8(logic [63:0] mean);
    logic [63:0] v, rem, root, trial;
    v = mean << 16;
    rem = 0;
    root = 0;
    for (int p = 31; p >= 0; p--) begin
      rem = (rem << 2) | ((v >> (2 * p)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [RmsBits-1:0] scaled_rms(logic [SumW-1:0] sum,
                                                    logic [CntW-1:0] cnt,
                                                    logic [ScaleBits-1:0] scale);
    logic [63:0] prod;
    prod = (root_q8(64'(sum) / 64'(cnt)) * 64'(scale)) >> ScaleFrac;
    if (prod > 64'((1 << RmsBits) - 1)) return '1;
    return prod[RmsBits-1:0];
  endfunction

  function automatic rms_t predict_rms(batch_t b);
    rms_t r;
    logic [63:0] pw;
    r = '0;
    if (b.sample_count == 0) return r;
    r.data_valid = 1'b1;
    r.rms_current_a = scaled_rms(b.current_sq_sum_a, b.sample_count, cur_scale);
    r.rms_current_b = scaled_rms(b.current_sq_sum_b, b.sample_count, cur_scale);
    r.rms_voltage_a = scaled_rms(b.voltage_sq_sum_a, b.sample_count, volt_scale);
    r.rms_voltage_b = scaled_rms(b.voltage_sq_sum_b, b.sample_count, volt_scale);
    pw = (64'(r.rms_current_a) * 64'(r.rms_voltage_a)) >> 8;
    if (pw > {24'd0, {PowerBits{1'b1}}}) pw = {24'd0, {PowerBits{1'b1}}};
    r.apparent_power_a = pw[PowerBits-1:0];
    return r;
  endfunction

  function automatic int gap_len();
    int d;
    if (calm) return 0;
    d = $urandom_range(0, 99);
    if (d < 60) return 0;
    if (d < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) expected_rms.push_back(predict_rms(in_ch.data));
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_batches.size() > 0) begin
          in_ch.data <= pending_batches.pop_front();
          in_ch.valid <= 1'b1;
          in_gap <= gap_len();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    rms_t exp_r, got;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_rms.size() == 0) begin
          $error("unexpected result beat %h", got);
          errors++;
        end else begin
          exp_r = expected_rms.pop_front();
          if (got.data_valid !== exp_r.data_valid) begin
            $error("data_valid exp %h got %h", exp_r.data_valid, got.data_valid); errors++;
          end
          if (got.rms_current_a !== exp_r.rms_current_a) begin
            $error("rms_current_a exp %h got %h", exp_r.rms_current_a, got.rms_current_a);
            errors++;
          end
          if (got.rms_current_b !== exp_r.rms_current_b) begin
            $error("rms_current_b exp %h got %h", exp_r.rms_current_b, got.rms_current_b);
            errors++;
          end
          if (got.rms_voltage_a !== exp_r.rms_voltage_a) begin
            $error("rms_voltage_a exp %h got %h", exp_r.rms_voltage_a, got.rms_voltage_a);
            errors++;
          end
          if (got.rms_voltage_b !== exp_r.rms_voltage_b) begin
            $error("rms_voltage_b exp %h got %h", exp_r.rms_voltage_b, got.rms_voltage_b);
            errors++;
          end
          if (got.apparent_power_a !== exp_r.apparent_power_a) begin
            $error("apparent_power_a exp %h got %h", exp_r.apparent_power_a,
                   got.apparent_power_a);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_gap <= gap_len();
      end
    end
  end

  task automatic write_scale(logic idx, logic [ScaleBits-1:0] val);
    @(posedge clk);
    we <= 1'b1;
    index <= idx;
    wdata <= val;
    @(posedge clk);
    we <= 1'b0;
    if (idx == RegCurrentScale) cur_scale = val;
    else volt_scale = val;
  endtask

  task automatic drain();
    while (pending_batches.size() > 0 || in_ch.valid || expected_rms.size() > 0)
      @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic logic [SumW-1:0] rand_sum();
    logic [63:0] w;
    int d;
    w = {$urandom, $urandom};
    d = $urandom_range(0, 9);
    if (d < 4) return w[SumW-1:0];
    if (d < 7) return w[SumW-1:0] >> $urandom_range(0, SumW - 1);
    if (d < 8) return '1;
    return SumW'($urandom_range(0, 20));
  endfunction

  function automatic batch_t rand_batch();
    batch_t b;
    int d;
    b.current_sq_sum_a = rand_sum();
    b.current_sq_sum_b = rand_sum();
    b.voltage_sq_sum_a = rand_sum();
    b.voltage_sq_sum_b = rand_sum();
    d = $urandom_range(0, 19);
    if (d == 0) b.sample_count = '0;
    else if (d < 3) b.sample_count = 1;
    else if (d < 4) b.sample_count = '1;
    else b.sample_count = CntW'($urandom_range(1, (1 << CntW) - 1));
    return b;
  endfunction

  task automatic add_batch(logic [SumW-1:0] ia, ib, va, vb, logic [CntW-1:0] n);
    batch_t b;
    b.current_sq_sum_a = ia;
    b.current_sq_sum_b = ib;
    b.voltage_sq_sum_a = va;
    b.voltage_sq_sum_b = vb;
    b.sample_count = n;
    pending_batches.push_back(b);
  endtask

  initial begin
    logic [ScaleBits-1:0] cs[6], vs[6];
    cs = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0, 32'd0};
    vs = '{32'd65536, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, reset scales
    add_batch('0, '0, '0, '0, '0);
    add_batch('1, '1, '1, '1, '0);
    add_batch('1, '1, '1, '1, 1);
    add_batch('1, '1, '1, '1, '1);
    add_batch(1, 1, 1, 1, 1);
    add_batch(0, 1, 2, 3, 1);
    add_batch(4, 9, 16, 25, 1);
    add_batch(100, 99, 101, 1000, 10);
    add_batch(42'h3FF_FFFF_FFFF, 0, 42'h3FF_FFFF_FFFF, 0, 12'h800);
    add_batch(42'h155_5555_5555, 42'h2AA_AAAA_AAAA, 42'h2AA_AAAA_AAAA,
              42'h155_5555_5555, 12'h555);
    add_batch(42'h2AA_AAAA_AAAA, 42'h155_5555_5555, 42'h155_5555_5555,
              42'h2AA_AAAA_AAAA, 12'hAAA);
    add_batch(3, 8, 15, 24, 1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 6) begin
        cs[ph] = (ph >= 4) ? $urandom : cs[ph];
        vs[ph] = (ph >= 4) ? ($urandom >> $urandom_range(0, 24)) : vs[ph];
        write_scale(RegCurrentScale, cs[ph]);
        write_scale(RegVoltageScale, vs[ph]);
      end else begin
        write_scale(RegCurrentScale, $urandom_range(1 << 12, 1 << 20));
        write_scale(RegVoltageScale, $urandom_range(1 << 12, 1 << 20));
      end
      if (ph == 1) begin
        add_batch('1, 1, '1, 1, 1);
        add_batch('1, '1, '1, '1, '1);
      end
      calm = (ph == 3);
      repeat (92) pending_batches.push_back(rand_batch());
      drain();
    end

    if (expected_rms.size() != 0) begin
      $error("%0d result beats missing", expected_rms.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[rms_power_from_square_sums] OK");
    end else begin
      $display("[rms_power_from_square_sums] ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[rms_power_from_square_sums] ERROR");
    $finish;
  end
endmodule
